// ----- sv/multichannel_step_quantised_clock_defines.svh -----
// assertion macros for the step-quantised clock
`ifndef MULTICHANNEL_STEP_QUANTISED_CLOCK_DEFINES_SVH
`define MULTICHANNEL_STEP_QUANTISED_CLOCK_DEFINES_SVH

// same-cycle implication
`define MCSQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mcsq_pkg.sv -----
// shared constants for the step-quantised clock
`default_nettype none
package mcsq_pkg;
  localparam int CHANNELS_DEF = 5;
  localparam int RATE_REGS    = 5;
  localparam int TIME_W   = 48;
  localparam int DELTA_W  = 24;
  localparam int CH_W     = 3;
  localparam int SEED_W   = 32;
  localparam int STEP_W   = 32;
  localparam int PROD_W   = 40;
  localparam int RATE_W   = 24;
  localparam int SCALE_W  = 16;
  localparam int JIT_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [PROD_W-1:0] STEP_NUM  = 40'd1048576000000;
  localparam logic [TIME_W-1:0] RAW_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [STEP_W-1:0] STEP_MAX  = 32'hFFFF_FFFF;
  localparam logic [31:0]       HASH_C1   = 32'h7feb352d;
  localparam logic [31:0]       HASH_C2   = 32'h846ca68b;
  localparam logic [JIT_W-1:0]  JIT_ONE   = 17'd65536;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE0  = 3'd3;

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_QUERY   = 1'b1;
endpackage
`default_nettype wire

// ----- sv/mcsq_in_if.sv -----
// input command channel
`default_nettype none
interface mcsq_in_if;
  import mcsq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [DELTA_W-1:0] time_delta;
  logic [CH_W-1:0]          channel;
  logic [SEED_W-1:0]        seed;
  modport source (output valid, command, time_delta, channel, seed, input ready);
  modport sink   (input valid, command, time_delta, channel, seed, output ready);
endinterface
`default_nettype wire

// ----- sv/mcsq_out_if.sv -----
// result channel
`default_nettype none
interface mcsq_out_if;
  import mcsq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          channel_index;
  logic signed [TIME_W-1:0] held_time;
  logic [STEP_W-1:0]        step_delta;
  logic                     stepped;
  logic                     last;
  modport source (output valid, channel_index, held_time, step_delta, stepped, last,
                  input ready);
  modport sink   (input valid, channel_index, held_time, step_delta, stepped, last,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/mcsq_cfg_if.sv -----
// configuration write channel
`default_nettype none
interface mcsq_cfg_if;
  import mcsq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/multichannel_step_quantised_clock.sv -----
// top level: raw time, per-channel step grids, seeded phase queries
// An advance command walks the channels in turn. A stepped channel starts the step-length
// division, waits on the shared 48-iteration divider, starts and waits on it again for the
// grid floor, and then loads the output register. A channel with no step loads the output
// register straight after the step-length check, or after the division when it gives a
// zero step. A seeded query divides for the step, forms the hash and the offset products in
// six registered steps, takes the two grid floors on the divider and then loads the result.
// A full output register that is not taken holds back the load of a result. The block
// takes no new command until the last result of the current one is in the output register;
// that register lets the next command start while the result waits. Configuration writes
// are accepted every cycle and must only be made while no command is in progress.
`default_nettype none
`include "multichannel_step_quantised_clock_defines.svh"
module multichannel_step_quantised_clock #(
  parameter int CHANNELS = mcsq_pkg::CHANNELS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mcsq_in_if.sink   in_if,
  mcsq_out_if.source out_if,
  mcsq_cfg_if.sink  cfg_if
);
  import mcsq_pkg::*;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PROD   = 5'd1;
  localparam logic [4:0] S_SWAIT  = 5'd2;
  localparam logic [4:0] S_GDIV   = 5'd3;
  localparam logic [4:0] S_GWAIT  = 5'd4;
  localparam logic [4:0] S_AEMIT  = 5'd5;
  localparam logic [4:0] S_QH1    = 5'd6;
  localparam logic [4:0] S_QH2    = 5'd7;
  localparam logic [4:0] S_QH3    = 5'd8;
  localparam logic [4:0] S_QMA    = 5'd9;
  localparam logic [4:0] S_QMB    = 5'd10;
  localparam logic [4:0] S_QOFF   = 5'd11;
  localparam logic [4:0] S_QD1    = 5'd12;
  localparam logic [4:0] S_QW1    = 5'd13;
  localparam logic [4:0] S_QD2    = 5'd14;
  localparam logic [4:0] S_QW2    = 5'd15;
  localparam logic [4:0] S_QEMIT  = 5'd16;
  localparam logic [4:0] S_QPLAIN = 5'd17;
  localparam logic [4:0] S_QBAD   = 5'd18;

  // configuration
  logic               en_r;
  logic [SCALE_W-1:0] scale_r;
  logic [JIT_W-1:0]   jit_r;
  logic [RATE_W-1:0]  rate_r [RATE_REGS];

  // clock state
  logic [TIME_W-1:0] raw_r, prev_r;
  logic [TIME_W-1:0] ctime_r  [CHANNELS];
  logic [STEP_W-1:0] cdelta_r [CHANNELS];
  logic [STEP_W-1:0] astep_r  [CHANNELS];
  logic              primed_r;

  // sequencer
  logic [4:0]        state_r;
  logic [CH_W-1:0]   ch_r;
  logic [SEED_W-1:0] seed_r;
  logic [STEP_W-1:0] step_r;
  logic [31:0]       hx_r;
  logic [40:0]       hj_r;
  logic [56:0]       pa_r, pb_r;
  logic [STEP_W-1:0] off_r;
  logic [TIME_W-1:0] q1_r;
  // query flag of the transaction in progress
  logic              qmode_r;

  // output register
  logic              out_valid_r;
  logic [CH_W-1:0]   out_ch_r;
  logic [TIME_W-1:0] out_held_r;
  logic [STEP_W-1:0] out_delta_r;
  logic              out_stepped_r, out_last_r;

  // divider
  logic              div_start, div_done;
  logic [TIME_W-1:0] div_a, div_q;
  logic [PROD_W-1:0] div_b, div_r;

  mcsq_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  logic              in_acc, slot_free, emit_c;
  logic [TIME_W-1:0] dt, raw_sum, rawoff, prevoff;
  logic [PROD_W-1:0] prod;
  logic [STEP_W-1:0] step_c;
  logic [JIT_W-1:0]  jit_c;
  logic [31:0]       hx1;
  logic [23:0]       h24;
  logic [57:0]       off_sum;
  logic [TIME_W-1:0] time_c, diff_c, old_c;
  logic [STEP_W-1:0] d32, adelta;
  logic [IDX_W-1:0]  idx;

  assign in_acc    = in_if.valid && in_if.ready;
  assign slot_free = !out_valid_r || out_if.ready;
  assign emit_c    = slot_free && (state_r == S_AEMIT || state_r == S_QEMIT ||
                                   state_r == S_QPLAIN || state_r == S_QBAD);
  assign idx       = ch_r[IDX_W-1:0];

  always_comb begin
    dt      = in_if.time_delta[DELTA_W-1] ? '0
                                          : {{(TIME_W-DELTA_W){1'b0}}, in_if.time_delta};
    raw_sum = raw_r + dt;
    if (raw_sum > RAW_MAX) raw_sum = RAW_MAX;
    prod    = {{(PROD_W-RATE_W){1'b0}}, rate_r[ch_r]}
            * {{(PROD_W-SCALE_W){1'b0}}, scale_r};
    step_c  = (div_q[TIME_W-1:STEP_W] != '0) ? STEP_MAX : div_q[STEP_W-1:0];
    jit_c   = (jit_r > JIT_ONE) ? JIT_ONE : jit_r;
    hx1     = hx_r ^ (hx_r >> 16);
    h24     = hx1[31:8];
    off_sum = {1'b0, pa_r} + {17'b0, pb_r[56:16]};
    rawoff  = raw_r + {{(TIME_W-STEP_W){1'b0}}, off_r};
    prevoff = prev_r + {{(TIME_W-STEP_W){1'b0}}, off_r};
    // advance: grid floor is raw minus remainder, or raw itself when the step is zero
    time_c  = (step_r != '0) ? (raw_r - {{(TIME_W-PROD_W){1'b0}}, div_r}) : raw_r;
    old_c   = ctime_r[idx];
    diff_c  = time_c - old_c;
    if (time_c > old_c) d32 = (diff_c[TIME_W-1:STEP_W] != '0) ? STEP_MAX
                                                               : diff_c[STEP_W-1:0];
    else                d32 = '0;
    adelta  = (primed_r && step_r != astep_r[idx]) ? '0 : d32;
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = raw_r;
    div_b     = {{(PROD_W-STEP_W){1'b0}}, step_r};
    case (state_r)
      S_PROD: begin
        div_start = en_r && prod != '0;
        div_a     = {{(TIME_W-PROD_W){1'b0}}, STEP_NUM};
        div_b     = prod;
      end
      S_GDIV: div_start = 1'b1;
      S_QD1: begin
        div_start = 1'b1;
        div_a     = rawoff;
      end
      S_QD2: begin
        div_start = 1'b1;
        div_a     = prevoff;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b1;
      scale_r <= SCALE_RST;
      jit_r   <= '0;
      for (int i = 0; i < RATE_REGS; i++) rate_r[i] <= '0;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        REG_ENABLE: en_r    <= cfg_if.data[0];
        REG_SCALE:  scale_r <= cfg_if.data[SCALE_W-1:0];
        REG_JITTER: jit_r   <= cfg_if.data[JIT_W-1:0];
        default: begin
          if (cfg_if.index >= REG_RATE0)
            rate_r[cfg_if.index - REG_RATE0] <= cfg_if.data[RATE_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      raw_r       <= '0;
      prev_r      <= '0;
      primed_r    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        ctime_r[i]  <= '0;
        cdelta_r[i] <= '0;
        astep_r[i]  <= '0;
      end
    end else begin
      if (out_if.ready && !emit_c) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            seed_r <= in_if.seed;
            if (in_if.command == CMD_ADVANCE) begin
              prev_r  <= raw_r;
              raw_r   <= raw_sum;
              ch_r    <= '0;
              state_r <= S_PROD;
            end else begin
              ch_r    <= in_if.channel;
              state_r <= (in_if.channel > LAST_CH) ? S_QBAD : S_PROD;
            end
          end
        end
        S_PROD: begin
          if (!en_r || prod == '0) begin
            step_r  <= '0;
            state_r <= qmode_r ? S_QPLAIN : S_AEMIT;
          end else begin
            state_r <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (div_done) begin
            step_r <= step_c;
            if (step_c == '0)            state_r <= qmode_r ? S_QPLAIN : S_AEMIT;
            else if (!qmode_r)           state_r <= S_GDIV;
            else if (jit_c == '0)        state_r <= S_QPLAIN;
            else                         state_r <= S_QH1;
          end
        end
        S_GDIV:  state_r <= S_GWAIT;
        S_GWAIT: if (div_done) state_r <= S_AEMIT;
        S_AEMIT: begin
          if (slot_free) begin
            out_valid_r   <= 1'b1;
            out_ch_r      <= ch_r;
            out_held_r    <= time_c;
            out_delta_r   <= adelta;
            out_stepped_r <= (step_r == '0) || (adelta != '0);
            out_last_r    <= (ch_r == LAST_CH);
            ctime_r[idx]  <= time_c;
            cdelta_r[idx] <= adelta;
            astep_r[idx]  <= step_r;
            if (ch_r == LAST_CH) begin
              primed_r <= 1'b1;
              state_r  <= S_IDLE;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_PROD;
            end
          end
        end
        S_QH1: begin
          hx_r    <= (seed_r ^ (seed_r >> 16)) * HASH_C1;
          state_r <= S_QH2;
        end
        S_QH2: begin
          hx_r    <= (hx_r ^ (hx_r >> 15)) * HASH_C2;
          state_r <= S_QH3;
        end
        S_QH3: begin
          hj_r    <= {17'b0, h24} * {24'b0, jit_c};
          state_r <= S_QMA;
        end
        S_QMA: begin
          pa_r    <= {16'b0, hj_r} * {41'b0, step_r[31:16]};
          state_r <= S_QMB;
        end
        S_QMB: begin
          pb_r    <= {16'b0, hj_r} * {41'b0, step_r[15:0]};
          state_r <= S_QOFF;
        end
        S_QOFF: begin
          off_r   <= off_sum[55:24];
          state_r <= S_QD1;
        end
        S_QD1: state_r <= S_QW1;
        S_QW1: begin
          if (div_done) begin
            q1_r    <= rawoff - {{(TIME_W-PROD_W){1'b0}}, div_r};
            state_r <= S_QD2;
          end
        end
        S_QD2: state_r <= S_QW2;
        S_QW2: if (div_done) state_r <= S_QEMIT;
        S_QEMIT: begin
          if (slot_free) begin
            out_valid_r   <= 1'b1;
            out_ch_r      <= ch_r;
            out_held_r    <= q1_r - {{(TIME_W-STEP_W){1'b0}}, off_r};
            out_delta_r   <= '0;
            out_stepped_r <= q1_r != (prevoff - {{(TIME_W-PROD_W){1'b0}}, div_r});
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        S_QPLAIN: begin
          if (slot_free) begin
            out_valid_r   <= 1'b1;
            out_ch_r      <= ch_r;
            out_held_r    <= ctime_r[idx];
            out_delta_r   <= '0;
            out_stepped_r <= (step_r == '0) || (cdelta_r[idx] != '0);
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        S_QBAD: begin
          if (slot_free) begin
            out_valid_r   <= 1'b1;
            out_ch_r      <= ch_r;
            out_held_r    <= '0;
            out_delta_r   <= '0;
            out_stepped_r <= 1'b1;
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) qmode_r <= 1'b0;
    else if (in_acc) qmode_r <= (in_if.command == CMD_QUERY);
  end

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid         = out_valid_r;
  assign out_if.channel_index = out_ch_r;
  assign out_if.held_time     = out_held_r;
  assign out_if.step_delta    = out_delta_r;
  assign out_if.stepped       = out_stepped_r;
  assign out_if.last          = out_last_r;

  `MCSQ_ASSERT_NOW(a_div_waited, clk, rst_n, div_done, (state_r == S_SWAIT || state_r == S_GWAIT || state_r == S_QW1 || state_r == S_QW2), "divider finished outside a wait state")
  `MCSQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, (state_r != S_IDLE), "accepted transaction left no work")
  `MCSQ_ASSERT_NOW(a_last_channel, clk, rst_n, (out_if.valid && !out_if.last), (out_if.channel_index < LAST_CH), "non-final result on the final channel")
endmodule
`default_nettype wire

// ----- sv/mcsq_div.sv -----
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module mcsq_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [mcsq_pkg::TIME_W-1:0]  dividend,
  input  wire logic [mcsq_pkg::PROD_W-1:0]  divisor,
  output logic                              done,
  output logic [mcsq_pkg::TIME_W-1:0]       quot,
  output logic [mcsq_pkg::PROD_W-1:0]       rem
);
  import mcsq_pkg::*;
  localparam int CNT_W = $clog2(TIME_W);

  logic [TIME_W-1:0] q_r, q_nxt;
  logic [PROD_W-1:0] r_r, r_nxt, d_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [PROD_W:0]   trial;

  always_comb begin
    trial = {r_r, q_r[TIME_W-1]};
    if (trial >= {1'b0, d_r}) begin
      r_nxt = PROD_W'(trial - {1'b0, d_r});
      q_nxt = {q_r[TIME_W-2:0], 1'b1};
    end else begin
      r_nxt = trial[PROD_W-1:0];
      q_nxt = {q_r[TIME_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      r_r   <= '0;
      d_r   <= divisor;
      cnt_r <= CNT_W'(TIME_W - 1);
    end else if (busy_r) begin
      q_r   <= q_nxt;
      r_r   <= r_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule
`default_nettype wire
